// ===== rtl/tepm_pkg.sv =====
package tepm_pkg;

  localparam int NUM_PATTERNS_DEF = 8;
  localparam int MAX_STEPS_DEF    = 8;
  localparam int TIME_BITS_DEF    = 32;

  // input item modes
  localparam logic [2:0] MODE_UPDATE = 3'd0;
  localparam logic [2:0] MODE_STEP   = 3'd1;
  localparam logic [2:0] MODE_HEADER = 3'd2;
  localparam logic [2:0] MODE_ARM    = 3'd3;
  localparam logic [2:0] MODE_RESTART = 3'd4;
  localparam logic [2:0] MODE_QUERY  = 3'd5;

  // configuration register indexes
  localparam logic [0:0] CFG_IN_USE = 1'b0;
  localparam logic [0:0] CFG_PAUSED = 1'b1;

  // progress codes
  localparam logic [2:0] ST_INACTIVE = 3'd0;
  localparam logic [2:0] ST_ACTIVE   = 3'd1;
  localparam logic [2:0] ST_PENDING  = 3'd2;
  localparam logic [2:0] ST_JUST     = 3'd3;
  localparam logic [2:0] ST_MATCHED  = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic start;   // latch item, clear result flags
    logic slot_go; // process the current slot (step row read is valid)
    logic finish;  // compute summary into output register; commit step and header writes
  } tepm_cmd_t;

endpackage

// ===== rtl/tepm_ctrl.sv =====
module tepm_ctrl
  import tepm_pkg::*;
#(
  parameter int SLOT_BITS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 out_taken,
  input  logic [SLOT_BITS:0]   slot_limit,
  input  logic                 slot_hold,
  output logic [SLOT_BITS:0]   slot_idx,
  output tepm_cmd_t            cmd,
  output logic                 out_valid
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SLOT, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [SLOT_BITS:0]   idx_r, idx_nxt;
  logic                 ov_r, ov_nxt;

  // a new item may enter once the controller is idle and the previous result has gone
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign slot_idx  = idx_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_taken;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.start = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      // row read for slot idx is registered here
      S_READ: begin
        if (idx_r >= slot_limit) state_nxt = S_DONE;
        else state_nxt = S_SLOT;
      end
      // stay on the same slot while the datapath asks for another row
      S_SLOT: begin
        cmd.slot_go = 1'b1;
        if (!slot_hold) idx_nxt = idx_r + 1'b1;
        state_nxt   = S_READ;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== rtl/tepm_dp.sv =====
module tepm_dp
  import tepm_pkg::*;
#(
  parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
  parameter int MAX_STEPS    = MAX_STEPS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF,
  parameter int SLOT_BITS    = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_idx,
  input  logic [3:0]            cfg_val,
  input  tepm_cmd_t             cmd,
  input  logic [SLOT_BITS:0]    slot_idx,
  output logic [SLOT_BITS:0]    slot_limit,
  output logic                  slot_hold,
  input  logic [120:0]          item_data,
  output logic [11:0]           result
);

  localparam int STEP_BITS = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int DEPTH     = NUM_PATTERNS * MAX_STEPS;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_BITS  = $clog2(MAX_STEPS + 1);
  localparam int SI_BITS   = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int MAP_N     = (NUM_PATTERNS < 8) ? NUM_PATTERNS : 8;
  localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;

  // fields of the latched item
  logic [120:0] it_r;
  logic [2:0]   mode;
  logic [31:0]  now32, tmin, tmax;
  logic         rise, fall, rel, unl_in;
  logic [2:0]   in_slot, in_step;
  logic [3:0]   cnt;
  logic [7:0]   tag;

  assign mode    = it_r[2:0];
  assign now32   = it_r[34:3];
  assign rise    = it_r[35];
  assign fall    = it_r[36];
  assign rel     = it_r[37];
  assign in_slot = it_r[40:38];
  assign in_step = it_r[43:41];
  assign tmin    = it_r[75:44];
  assign tmax    = it_r[107:76];
  assign unl_in  = it_r[108];
  assign cnt     = it_r[112:109];
  assign tag     = it_r[120:113];

  // configuration
  logic [3:0] in_use_r;
  logic       paused_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      paused_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_IN_USE) in_use_r <= cfg_val;
      else paused_r <= cfg_val[0];
    end
  end
  assign slot_limit = (int'(in_use_r) > NUM_PATTERNS) ? (SLOT_BITS+1)'(NUM_PATTERNS)
                      : (SLOT_BITS+1)'(in_use_r);

  // step memory, one row per step of each slot
  logic [2*32:0] step_mem [DEPTH];
  logic [STEP_BITS-1:0] step_lo;
  logic [SI_BITS-1:0]   cur_slot;
  logic [2*32:0]        row_r;
  logic                 step_ok_wr;

  assign cur_slot   = slot_idx[SI_BITS-1:0];
  assign step_ok_wr = (int'(in_slot) < NUM_PATTERNS) && (int'(in_step) < MAX_STEPS);

  // per-slot state
  logic [LEN_BITS-1:0]  len_r   [NUM_PATTERNS];
  logic [7:0]           id_r    [NUM_PATTERNS];
  logic [LEN_BITS-1:0]  cur_r   [NUM_PATTERNS];
  logic [TIME_BITS-1:0] t0_r    [NUM_PATTERNS];
  logic [2:0]           prog_r  [NUM_PATTERNS];
  logic                 err_r   [NUM_PATTERNS];

  // arm check walks steps within the slot one per visit via a sub-counter
  logic [LEN_BITS-1:0]  chk_r;
  logic                 bad_r;

  // read address: during arm, scan step chk_r; otherwise current step
  logic [LEN_BITS-1:0]  rd_step;
  assign rd_step = (mode == MODE_ARM) ? chk_r : cur_r[cur_slot];
  assign step_lo = (rd_step < LEN_BITS'(MAX_STEPS)) ? STEP_BITS'(rd_step) : '0;

  always_ff @(posedge clk) begin
    if (mode == MODE_STEP && cmd.finish && step_ok_wr)
      step_mem[ADDR_BITS'(in_slot) * ADDR_BITS'(MAX_STEPS) + ADDR_BITS'(in_step)] <=
        {unl_in, tmax, tmin};
    row_r <= step_mem[ADDR_BITS'(cur_slot) * ADDR_BITS'(MAX_STEPS) + ADDR_BITS'(step_lo)];
  end

  logic [31:0] r_min, r_max;
  logic        r_unl;
  assign r_min = row_r[31:0];
  assign r_max = row_r[63:32];
  assign r_unl = row_r[64];

  // flags gathered over the pass
  logic any_r, armok_r, qm_r, qfound_r;

  // per-slot update decision
  logic [TIME_BITS-1:0] now_t, elapsed;
  logic                 has_ev, expected;
  logic [CMP_BITS-1:0]  el_c, mn_c, mx_c;
  assign now_t   = TIME_BITS'({32'd0, now32});
  assign has_ev  = rise | fall;
  assign elapsed = now_t - t0_r[cur_slot];
  assign expected = cur_r[cur_slot][0] ? rise : fall;
  assign el_c = CMP_BITS'(elapsed);
  assign mn_c = CMP_BITS'(r_min);
  assign mx_c = CMP_BITS'(r_max);

  logic [2:0]          p;
  logic [LEN_BITS-1:0] s1;
  assign p  = prog_r[cur_slot];
  assign s1 = cur_r[cur_slot] + 1'b1;

  // arm scan needs one visit per step; the controller holds the slot meanwhile
  logic arm_bad_now;
  assign arm_bad_now = (chk_r < len_r[cur_slot]) && !r_unl && (r_max < r_min);
  assign slot_hold   = (mode == MODE_ARM) && (chk_r + 1'b1 < LEN_BITS'(MAX_STEPS)) &&
                       (chk_r + 1'b1 < len_r[cur_slot]);

  // summary over slots in use
  logic       all_off;
  logic [7:0] map;
  always_comb begin
    all_off = 1'b1;
    map     = '0;
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      if ((SLOT_BITS+1)'(i) < slot_limit) begin
        if (prog_r[i] != ST_INACTIVE) all_off = 1'b0;
        if (i < MAP_N && (prog_r[i] == ST_JUST || prog_r[i] == ST_MATCHED))
          map[i % 8] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        len_r[i]  <= '0;
        id_r[i]   <= '0;
        cur_r[i]  <= '0;
        t0_r[i]   <= '0;
        prog_r[i] <= ST_INACTIVE;
        err_r[i]  <= 1'b0;
      end
      it_r <= '0;
      chk_r <= '0;
      bad_r <= 1'b0;
      any_r <= 1'b0; armok_r <= 1'b0; qm_r <= 1'b0; qfound_r <= 1'b0;
      result <= '0;
    end else begin
      if (cmd.start) begin
        it_r     <= item_data;
        any_r    <= 1'b0;
        armok_r  <= 1'b1;
        qm_r     <= 1'b0;
        qfound_r <= 1'b0;
        chk_r    <= '0;
        bad_r    <= 1'b0;
      end
      if (cmd.slot_go) begin
        case (mode)
          MODE_UPDATE: begin
            if (!paused_r) begin
              if (err_r[cur_slot]) prog_r[cur_slot] <= ST_INACTIVE;
              else if (p == ST_JUST) prog_r[cur_slot] <= ST_MATCHED;
              else if (p == ST_ACTIVE) begin
                if (rise && !rel) prog_r[cur_slot] <= ST_INACTIVE;
                else if (rise) begin
                  cur_r[cur_slot]  <= '0;
                  t0_r[cur_slot]   <= now_t;
                  prog_r[cur_slot] <= ST_PENDING;
                end
              end else if (p == ST_PENDING) begin
                if ((!expected && has_ev) || (has_ev && !rel))
                  prog_r[cur_slot] <= ST_INACTIVE;
                else if (!r_unl && el_c > mx_c)
                  prog_r[cur_slot] <= ST_INACTIVE;
                else if (has_ev) begin
                  if (el_c < mn_c) prog_r[cur_slot] <= ST_INACTIVE;
                  else begin
                    cur_r[cur_slot] <= s1;
                    if (s1 >= len_r[cur_slot]) begin
                      prog_r[cur_slot] <= ST_JUST;
                      any_r <= 1'b1;
                    end else begin
                      t0_r[cur_slot] <= now_t;
                    end
                  end
                end else if (s1 >= len_r[cur_slot] && r_unl && el_c >= mn_c) begin
                  prog_r[cur_slot] <= ST_JUST;
                  any_r <= 1'b1;
                end
              end
            end
          end
          MODE_ARM: begin
            // one step of the current slot per visit; row_r holds step chk_r
            if (slot_hold) begin
              chk_r <= chk_r + 1'b1;
              bad_r <= bad_r | arm_bad_now;
            end else begin
              chk_r <= '0;
              bad_r <= 1'b0;
              cur_r[cur_slot] <= '0;
              t0_r[cur_slot]  <= '0;
              if (len_r[cur_slot] == '0 || bad_r || arm_bad_now) begin
                prog_r[cur_slot] <= ST_INACTIVE;
                err_r[cur_slot]  <= 1'b1;
                armok_r          <= 1'b0;
              end else begin
                prog_r[cur_slot] <= ST_ACTIVE;
                err_r[cur_slot]  <= 1'b0;
              end
            end
          end
          MODE_RESTART: begin
            cur_r[cur_slot] <= '0;
            t0_r[cur_slot]  <= '0;
            if (!err_r[cur_slot]) prog_r[cur_slot] <= ST_ACTIVE;
          end
          MODE_QUERY: begin
            if (!qfound_r && id_r[cur_slot] == tag) begin
              qfound_r <= 1'b1;
              qm_r <= (prog_r[cur_slot] == ST_JUST) || (prog_r[cur_slot] == ST_MATCHED);
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (mode == MODE_HEADER && int'(in_slot) < NUM_PATTERNS) begin
          len_r[SI_BITS'(in_slot)] <= (int'(cnt) > MAX_STEPS) ? LEN_BITS'(MAX_STEPS)
                                      : LEN_BITS'(cnt);
          id_r[SI_BITS'(in_slot)]  <= tag;
        end
        result[0] <= any_r && mode == MODE_UPDATE;
        result[1] <= all_off;
        result[2] <= armok_r && mode == MODE_ARM;
        result[3] <= qm_r && mode == MODE_QUERY;
        result[11:4] <= map;
      end
    end
  end

endmodule

// ===== rtl/timed_edge_pattern_matcher.sv =====
// channel | dir | payload
// in      | in  | mode, now_ms, edges, slot, step, times, count, tag
// out     | out | any-match flag, all-idle flag, arm_ok, query_matched, matched_map
// cfg     | in  | index 0 patterns_in_use, index 1 paused
// after the input transfer each slot in use gets a row read and a visit, then the
// result is registered; an arm visits each slot once per checked step (at least one
// step per slot) instead of once per slot, set by the single step-row read port
// reset is synchronous; step rows are undefined until written
// a new item enters only after the previous result has been transferred, so
// items never overlap inside the block
module timed_edge_pattern_matcher
  import tepm_pkg::*;
#(
  parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
  parameter int MAX_STEPS    = MAX_STEPS_DEF,
  parameter int TIME_BITS    = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode, now_ms, rise, fall, edge_reliable, slot, step_number,
  // min_time, max_time, no_upper_limit, step_count, pattern_tag
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // any-match flag, all-idle flag, arm_ok, query_matched, matched_map
  output logic [15:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  localparam int SLOT_BITS = $clog2(NUM_PATTERNS + 1);

  tepm_cmd_t            cmd;
  logic [SLOT_BITS-1:0] slot_idx, slot_limit;
  logic                 slot_hold;
  logic [11:0]          result;

  assign cfg_ready = 1'b1;
  assign out_tdata = {4'd0, result};

  tepm_ctrl #(.SLOT_BITS(SLOT_BITS-1)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .out_taken(out_tvalid && out_tready),
    .slot_limit, .slot_hold, .slot_idx, .cmd, .out_valid(out_tvalid)
  );

  tepm_dp #(
    .NUM_PATTERNS(NUM_PATTERNS), .MAX_STEPS(MAX_STEPS),
    .TIME_BITS(TIME_BITS), .SLOT_BITS(SLOT_BITS-1)
  ) u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .cmd, .slot_idx, .slot_limit, .slot_hold,
    .item_data(in_tdata[120:0]), .result
  );

endmodule
